### src/tga_rle_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// tga_rle_decoder_core_macros.svh
// assertion macros used by the top-level decoder file
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_DECODER_CORE_MACROS_SVH
`define TGA_RLE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property holds on every clock edge outside reset
`define TRD_ASSERT_HOLD(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define TRD_ASSERT_HOLD(lbl, clk, rstn, prop, msg)
`define TRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// types and constants of the run-length pixel decoder
// ----------------------------------------------------------------------------
package trd_pkg;

	localparam int unsigned CfgIdxW   = 1;
	localparam int unsigned CfgDataW  = 32;
	localparam int unsigned QueueDepth = 2;

	localparam logic [7:0] RunHdrBase = 8'd127;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} trd_reg_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_RAW    = 2'd1,
		PH_RUN    = 2'd2
	} trd_phase_t;

	typedef struct packed {
		logic                we;
		logic [CfgIdxW-1:0]  index;
		logic [CfgDataW-1:0] data;
	} trd_cfg_wr_t;

	typedef struct packed {
		logic [31:0] pixel;
		logic [7:0]  repeat_res;
		logic        last_of_frame;
		logic        overflow;
	} trd_item_t;

endpackage

### src/trd_queue.sv
// ----------------------------------------------------------------------------
// trd_queue
// short queue of decoded items between front and back
// ----------------------------------------------------------------------------
module trd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  trd_pkg::trd_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output trd_pkg::trd_item_t rd_item,
	output logic               avail
);
	import trd_pkg::*;

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	trd_item_t         mem_q [QueueDepth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   cnt_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (cnt_q == CntW'(QueueDepth));
	assign avail   = (cnt_q != '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && avail;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

### src/trd_front.sv
// ----------------------------------------------------------------------------
// trd_front
// packet parsing, pixel assembly and frame accounting, one byte a cycle
// ----------------------------------------------------------------------------
module trd_front #(
	parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  trd_pkg::trd_cfg_wr_t cfg,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	output logic                 out_valid,
	output trd_pkg::trd_item_t   out_item
);
	import trd_pkg::*;

	localparam logic [2:0] MaxBpp = 3'(MAX_BYTES_PER_PIXEL);

	logic [2:0]  bpp_q;
	logic [31:0] count_q;

	trd_phase_t  phase_q, phase_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic [1:0]  byte_idx_q, byte_idx_d;
	logic [31:0] asm_q, asm_d;
	logic [31:0] done_q, done_d;

	logic [2:0]  eff_bpp;
	logic [31:0] eff_count;
	logic [31:0] left;
	logic [1:0]  byte_idx_inc;
	logic [31:0] asm_new;
	logic        in_data;
	logic        pix_done;
	logic [7:0]  rep;
	logic [7:0]  pl_after;
	logic        last;
	logic        ovf;
	logic        restart;

	assign in_data = (phase_q == PH_RAW) || (phase_q == PH_RUN);

	always_comb begin
		eff_bpp = bpp_q;
		if (bpp_q == 3'd0) begin
			eff_bpp = 3'd1;
		end else if (bpp_q > MaxBpp) begin
			eff_bpp = MaxBpp;
		end
	end

	assign eff_count    = (count_q == 32'd0) ? 32'd1 : count_q;
	assign left         = eff_count - done_q;
	assign byte_idx_inc = byte_idx_q + 2'd1;
	assign asm_new      = asm_q | ({24'd0, in_byte} << {byte_idx_q, 3'b000});
	assign pix_done     = in_data && (byte_idx_inc == eff_bpp[1:0]);

	// result of a completed pixel
	always_comb begin
		rep      = 8'd1;
		pl_after = packet_left_q - 8'd1;
		last     = 1'b0;
		ovf      = 1'b0;
		if (phase_q == PH_RUN) begin
			rep      = packet_left_q;
			pl_after = 8'd0;
			if ({24'd0, packet_left_q} >= left) begin
				ovf  = ({24'd0, packet_left_q} > left);
				rep  = left[7:0];
				last = 1'b1;
			end
		end else if (left == 32'd1) begin
			last = 1'b1;
			ovf  = (pl_after != 8'd0);
		end
	end

	assign out_valid              = in_valid && pix_done && !cfg.we;
	assign out_item.pixel         = asm_new;
	assign out_item.repeat_res    = rep;
	assign out_item.last_of_frame = last;
	assign out_item.overflow      = ovf;

	assign restart = cfg.we || (in_valid && pix_done && last);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (restart) begin
			phase_d = PH_HEADER;
		end else if (in_valid) begin
			unique case (phase_q)
				PH_RAW, PH_RUN: begin
					if (pix_done && (pl_after == 8'd0)) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
					phase_d = in_byte[7] ? PH_RUN : PH_RAW;
				end
			endcase
		end
	end

	// datapath state
	always_comb begin
		packet_left_d = packet_left_q;
		byte_idx_d    = byte_idx_q;
		asm_d         = asm_q;
		done_d        = done_q;
		if (restart) begin
			packet_left_d = 8'd0;
			byte_idx_d    = 2'd0;
			asm_d         = 32'd0;
			done_d        = 32'd0;
		end else if (in_valid) begin
			if (!in_data) begin
				packet_left_d = in_byte[7] ? (in_byte - RunHdrBase) : (in_byte + 8'd1);
				byte_idx_d    = 2'd0;
				asm_d         = 32'd0;
			end else if (!pix_done) begin
				byte_idx_d = byte_idx_inc;
				asm_d      = asm_new;
			end else begin
				packet_left_d = pl_after;
				byte_idx_d    = 2'd0;
				asm_d         = 32'd0;
				done_d        = done_q + {24'd0, rep};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q         <= 3'd3;
			count_q       <= 32'd1;
			phase_q       <= PH_HEADER;
			packet_left_q <= 8'd0;
			byte_idx_q    <= 2'd0;
			asm_q         <= 32'd0;
			done_q        <= 32'd0;
		end else begin
			if (cfg.we) begin
				unique case (trd_reg_t'(cfg.index))
					REG_BYTES_PER_PIXEL: bpp_q   <= cfg.data[2:0];
					REG_PIXEL_COUNT:     count_q <= cfg.data;
				endcase
			end
			phase_q       <= phase_d;
			packet_left_q <= packet_left_d;
			byte_idx_q    <= byte_idx_d;
			asm_q         <= asm_d;
			done_q        <= done_d;
		end
	end

endmodule

### src/trd_back.sv
// ----------------------------------------------------------------------------
// trd_back
// output register stage, presents the oldest item to the consumer
// ----------------------------------------------------------------------------
module trd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_avail,
	input  trd_pkg::trd_item_t q_item,
	output logic               q_rd,
	input  logic               pop,
	output logic               empty,
	output trd_pkg::trd_item_t out_item
);
	import trd_pkg::*;

	logic      vld_q;
	trd_item_t item_q;

	assign empty    = !vld_q;
	assign q_rd     = q_avail && (!vld_q || pop);
	assign out_item = item_q;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			item_q <= q_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (q_rd) begin
			vld_q <= 1'b1;
		end else if (pop) begin
			vld_q <= 1'b0;
		end
	end

endmodule

### src/tga_rle_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_decoder_core
// run-length pixel stream decoder, one compressed byte per cycle while not full
// throughput: one byte every cycle while the consumer pops; input stalls with 3 items waiting
// a result reaches the result ports through the queue and then the output register
// the front decodes in the accept cycle, a 2-item queue and an output register follow
// reset clears all decode state; bytes_per_pixel resets to 3, pixel_count to 1
// ----------------------------------------------------------------------------
`include "tga_rle_decoder_core_macros.svh"

module tga_rle_decoder_core #(
	parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   data_byte,
	output logic                         empty,
	input  logic                         pop,
	output logic [31:0]                  pixel,
	output logic [7:0]                   repeat_res,
	output logic                         last_of_frame,
	output logic                         overflow,
	input  logic                         cfg_we,
	input  logic [trd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [trd_pkg::CfgDataW-1:0] cfg_data
);
	import trd_pkg::*;

	trd_cfg_wr_t cfg;
	logic        fr_valid;
	trd_item_t   fr_item;
	logic        q_avail;
	logic        q_rd;
	trd_item_t   q_item;
	trd_item_t   out_item;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	trd_front #(
		.MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (push && !full),
		.in_byte  (data_byte),
		.out_valid(fr_valid),
		.out_item (fr_item)
	);

	trd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_valid),
		.wr_item(fr_item),
		.full   (full),
		.rd_en  (q_rd),
		.rd_item(q_item),
		.avail  (q_avail)
	);

	trd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_item  (q_item),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.out_item(out_item)
	);

	assign pixel         = out_item.pixel;
	assign repeat_res    = out_item.repeat_res;
	assign last_of_frame = out_item.last_of_frame;
	assign overflow      = out_item.overflow;

	// overflow always ends the frame
	`TRD_ASSERT_IMPLY(a_ovf_last, clk, arst_n, !empty && overflow, last_of_frame, "overflow without frame end")
	// a run never carries zero or more than 128 pixels
	`TRD_ASSERT_IMPLY(a_rep_range, clk, arst_n, !empty, (repeat_res != 8'd0) && (repeat_res <= 8'd128), "repeat out of range")
	// the queue only drains into an empty or emptying output stage
	`TRD_ASSERT_HOLD(a_back_load, clk, arst_n, !q_rd || empty || pop, "output item overwritten")

endmodule
